// ----- design/cpac_pkg.sv -----
// Package for the cache purge amount calculator.
// Holds widths, the pipeline control struct and register address codes.
// No dependencies.
package cpac_pkg;
	localparam int unsigned VAL_W = 52;
	localparam int unsigned FRAC_BITS_DEFAULT = 32;
	localparam int unsigned ADDR_W = 6;
	localparam logic [ADDR_W-1:0] REG_BASELINE = 6'd0;
	localparam logic [ADDR_W-1:0] REG_NOMINAL = 6'd8;
	localparam logic [ADDR_W-1:0] REG_MAXIMUM = 6'd16;
	localparam logic [ADDR_W-1:0] REG_LOW_MARK = 6'd24;
	localparam logic [ADDR_W-1:0] REG_HIGH_MARK = 6'd32;
	localparam int unsigned QUO_W = 64;
	localparam logic [QUO_W-1:0] QUO_SAT = {QUO_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_SAT = {VAL_W{1'b1}};

	// Which branch of the decision an item took.
	localparam logic [1:0] PATH_ZERO = 2'd0;
	localparam logic [1:0] PATH_HIGH = 2'd1;
	localparam logic [1:0] PATH_MID = 2'd2;
	localparam logic [1:0] PATH_LOW = 2'd3;

	typedef struct packed {
		logic [1:0] path;
		logic full_disk;
		logic signed [VAL_W+1:0] cand;
		logic signed [VAL_W+1:0] x;
		logic signed [VAL_W+1:0] lo;
		logic signed [VAL_W+1:0] hi_a;
		logic signed [VAL_W+1:0] hi_b;
		logic [VAL_W-1:0] d;
		logic [VAL_W-1:0] m;
	} ctx_t;
endpackage

// ----- design/cpac_stream_if.sv -----
// Valid/ready channel interface carrying a payload of parameter width.
// Depends on nothing.
interface cpac_stream_if #(parameter int unsigned W = 52);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/cpac_regs.sv -----
// APB-style register file for the five watermark registers.
// Depends on cpac_pkg.
module cpac_regs import cpac_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	output logic [VAL_W-1:0] f0,
	output logic [VAL_W-1:0] f1,
	output logic [VAL_W-1:0] f2,
	output logic [VAL_W-1:0] w1,
	output logic [VAL_W-1:0] w2
);
	logic wr;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f0 <= '0;
			f1 <= '0;
			f2 <= '0;
			w1 <= '0;
			w2 <= '0;
		end else if (wr) begin
			unique case (paddr)
				REG_BASELINE: f0 <= pwdata[VAL_W-1:0];
				REG_NOMINAL: f1 <= pwdata[VAL_W-1:0];
				REG_MAXIMUM: f2 <= pwdata[VAL_W-1:0];
				REG_LOW_MARK: w1 <= pwdata[VAL_W-1:0];
				REG_HIGH_MARK: w2 <= pwdata[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr)
			REG_BASELINE: prdata = {12'd0, f0};
			REG_NOMINAL: prdata = {12'd0, f1};
			REG_MAXIMUM: prdata = {12'd0, f2};
			REG_LOW_MARK: prdata = {12'd0, w1};
			REG_HIGH_MARK: prdata = {12'd0, w2};
			default: prdata = '0;
		endcase
	end
endmodule

// ----- design/cpac_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Gives floor(n * 2^FRAC / m) saturated to 64 bits, or zero when n or m is zero.
// Depends on cpac_pkg.
module cpac_div import cpac_pkg::*; #(
	parameter int unsigned FRAC = FRAC_BITS_DEFAULT,
	parameter int unsigned TAG_W = 1
) (
	input logic clk,
	input logic en,
	input logic [VAL_W-1:0] n,
	input logic [VAL_W-1:0] m,
	input logic [TAG_W-1:0] tag_in,
	output logic [QUO_W-1:0] q,
	output logic [TAG_W-1:0] tag_out
);
	localparam int unsigned STEPS = VAL_W + FRAC;
	localparam int unsigned DW = VAL_W + FRAC;
	localparam int unsigned RW = VAL_W + 1;

	logic [DW-1:0] dvd_s [STEPS+1];
	logic [RW-1:0] rem_s [STEPS+1];
	logic [VAL_W-1:0] dvs_s [STEPS+1];
	logic [DW-1:0] quo_s [STEPS+1];
	logic zero_s [STEPS+1];
	logic [TAG_W-1:0] tag_s [STEPS+1];

	assign dvd_s[0] = {n, {FRAC{1'b0}}};
	assign rem_s[0] = '0;
	assign dvs_s[0] = m;
	assign quo_s[0] = '0;
	assign zero_s[0] = (n == '0) || (m == '0);
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [RW-1:0] r_sh;
		logic ge;
		assign r_sh = {rem_s[i][RW-2:0], dvd_s[i][DW-1]};
		assign ge = r_sh >= {1'b0, dvs_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[i+1] <= {dvd_s[i][DW-2:0], 1'b0};
				rem_s[i+1] <= ge ? r_sh - {1'b0, dvs_s[i]} : r_sh;
				dvs_s[i+1] <= dvs_s[i];
				quo_s[i+1] <= {quo_s[i][DW-2:0], ge};
				zero_s[i+1] <= zero_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	always_comb begin
		if (zero_s[STEPS]) begin
			q = '0;
		end else if (quo_s[STEPS][DW-1:QUO_W] != '0) begin
			q = QUO_SAT;
		end else begin
			q = quo_s[STEPS][QUO_W-1:0];
		end
		tag_out = tag_s[STEPS];
	end
endmodule

// ----- design/cpac_scale.sv -----
// Two-stage scale-back: floor(f * m / 2^FRAC) saturated to 52 bits.
// The 64x52 product is split into four partial products of at most 32x32.
// Depends on cpac_pkg.
module cpac_scale import cpac_pkg::*; #(
	parameter int unsigned FRAC = FRAC_BITS_DEFAULT
) (
	input logic clk,
	input logic en,
	input logic [QUO_W-1:0] f,
	input logic [VAL_W-1:0] m,
	output logic [VAL_W-1:0] res
);
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic [VAL_W-1:0] res_s2;
	logic [127:0] prod;
	logic [127:0] shr;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(f[31:0]) * 64'(m[31:0]);
			p01_s1 <= 64'(f[31:0]) * 64'(m[VAL_W-1:32]);
			p10_s1 <= 64'(f[63:32]) * 64'(m[31:0]);
			p11_s1 <= 64'(f[63:32]) * 64'(m[VAL_W-1:32]);
			res_s2 <= (shr[127:VAL_W] != '0) ? VAL_SAT : shr[VAL_W-1:0];
		end
	end

	assign prod = {64'd0, p00_s1} + {32'd0, p01_s1, 32'd0} + {32'd0, p10_s1, 32'd0}
		+ {p11_s1, 64'd0};
	assign shr = prod >> FRAC;
	assign res = res_s2;
endmodule

// ----- design/cache_purge_amount_calculator.sv -----
// Channel  Dir  Payload
// in_ch    in   disk_total, cache_usage, disk_used, recent_writes (52 bits each)
// out_ch   out  purge_bytes (52 bits)
// An item passes the input, decision, divider, compare, scale-back and output registers.
// A new item may enter in every cycle; the whole pipeline advances when the output
// stage is empty or being taken, so a stall holds every stage in place.
// Reset clears the valid bits and the watermark registers.
// Depends on cpac_pkg, cpac_stream_if, cpac_regs, cpac_div and cpac_scale.
module cache_purge_amount_calculator import cpac_pkg::*; #(
	parameter int unsigned FRACTION_BITS = FRAC_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	cpac_stream_if.sink in_ch,
	cpac_stream_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	localparam int unsigned SW = VAL_W + 2;
	localparam int unsigned DEPTH = VAL_W + FRACTION_BITS;
	localparam int unsigned CTX_W = $bits(ctx_t);
	localparam int unsigned LAT = DEPTH + 6;

	logic [VAL_W-1:0] f0, f1, f2, w1, w2;
	logic adv;
	logic [LAT-1:0] vld_q;

	cpac_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.f0, .f1, .f2, .w1, .w2
	);

	assign adv = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	// Stage 1: register inputs.
	logic signed [SW-1:0] t_s1, x_s1, u_s1, d_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= SW'(in_ch.data[4*VAL_W-1:3*VAL_W]);
			x_s1 <= SW'(in_ch.data[3*VAL_W-1:2*VAL_W]);
			u_s1 <= SW'(in_ch.data[2*VAL_W-1:VAL_W]);
			d_s1 <= SW'(in_ch.data[VAL_W-1:0]);
		end
	end

	// Stage 2: branch decision and divider operands.
	logic signed [SW-1:0] sf0, sf1, sf2, sw1, sw2;
	assign sf0 = SW'(f0);
	assign sf1 = SW'(f1);
	assign sf2 = SW'(f2);
	assign sw1 = SW'(w1);
	assign sw2 = SW'(w2);

	ctx_t ctx_c, ctx_s2;
	logic [VAL_W-1:0] nu_c, mu_c, nx_c, mx_c, nu_s2, mu_s2, nx_s2, mx_s2;

	function automatic logic [VAL_W-1:0] pos(input logic signed [SW-1:0] v);
		pos = (v > 0) ? v[VAL_W-1:0] : '0;
	endfunction

	always_comb begin
		logic signed [SW-1:0] top;
		top = sf2 - d_s1;
		if (top < sf0) begin
			top = sf0;
		end
		ctx_c = '0;
		ctx_c.x = x_s1;
		ctx_c.lo = sf0;
		ctx_c.d = d_s1[VAL_W-1:0];
		nu_c = '0;
		mu_c = '0;
		nx_c = '0;
		mx_c = '0;
		priority if (x_s1 < sf0) begin
			ctx_c.path = PATH_ZERO;
		end else if (u_s1 >= sw2 && sw2 != t_s1) begin
			ctx_c.path = PATH_HIGH;
			nu_c = pos(u_s1 - sw2);
			mu_c = pos(t_s1 - sw2);
			nx_c = pos(x_s1 - sf0);
			mx_c = pos(sf1 - sf0);
			ctx_c.m = mx_c;
			ctx_c.hi_a = sf1;
			ctx_c.hi_b = sf2;
		end else if (u_s1 > sw1 && x_s1 > sf1) begin
			ctx_c.path = PATH_MID;
			nu_c = pos(u_s1 - sw1);
			mu_c = pos(sw2 - sw1);
			nx_c = pos(x_s1 - sf1);
			mx_c = pos(sf2 - sf1);
			ctx_c.m = mx_c;
			ctx_c.hi_a = sf2;
			ctx_c.hi_b = sf2;
			ctx_c.full_disk = (u_s1 >= sw2);
			ctx_c.cand = u_s1 - sw1;
		end else if (x_s1 > sf2) begin
			ctx_c.path = PATH_LOW;
			ctx_c.hi_a = top;
			ctx_c.hi_b = top;
			ctx_c.full_disk = (u_s1 >= sw2);
			ctx_c.cand = u_s1 - sw1;
		end else begin
			ctx_c.path = PATH_ZERO;
			ctx_c.full_disk = (u_s1 >= sw2);
			ctx_c.cand = u_s1 - sw1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2 <= ctx_c;
			nu_s2 <= nu_c;
			mu_s2 <= mu_c;
			nx_s2 <= nx_c;
			mx_s2 <= mx_c;
		end
	end

	// Divider stages.
	logic [QUO_W-1:0] fu, fx;
	logic [CTX_W-1:0] ctx_bits;
	logic [0:0] unused_tag;

	cpac_div #(.FRAC(FRACTION_BITS), .TAG_W(1)) u_div_u (
		.clk, .en(adv), .n(nu_s2), .m(mu_s2), .tag_in(1'b0), .q(fu), .tag_out(unused_tag)
	);
	cpac_div #(.FRAC(FRACTION_BITS), .TAG_W(CTX_W)) u_div_x (
		.clk, .en(adv), .n(nx_s2), .m(mx_s2), .tag_in(ctx_s2), .q(fx), .tag_out(ctx_bits)
	);

	// Compare stage.
	ctx_t ctx_d;
	assign ctx_d = ctx_t'(ctx_bits);
	ctx_t ctx_s3, ctx_s4, ctx_s5;
	logic gt_s3;
	logic [QUO_W-1:0] diff_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3 <= ctx_d;
			gt_s3 <= (fx > fu) && !unused_tag[0];
			diff_s3 <= fx - fu;
		end
	end

	logic [VAL_W-1:0] sb;
	cpac_scale #(.FRAC(FRACTION_BITS)) u_scale (
		.clk, .en(adv), .f(diff_s3), .m(ctx_s3.m), .res(sb)
	);
	logic gt_s4, gt_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4 <= ctx_s3;
			gt_s4 <= gt_s3;
			ctx_s5 <= ctx_s4;
			gt_s5 <= gt_s4;
		end
	end

	// Final clamp and output register.
	logic [VAL_W-1:0] res_c, res_s6;
	always_comb begin
		logic signed [SW:0] b, r, hi, v;
		b = '0;
		hi = (SW+1)'(ctx_s5.hi_b);
		if (ctx_s5.path != PATH_HIGH && ctx_s5.full_disk) begin
			b = (SW+1)'(ctx_s5.cand);
		end
		if ((ctx_s5.path == PATH_HIGH || ctx_s5.path == PATH_MID) && gt_s5) begin
			b = (SW+1)'(sb) + (SW+1)'(ctx_s5.d);
			hi = (SW+1)'(ctx_s5.hi_a);
		end
		if (ctx_s5.path == PATH_LOW) begin
			hi = (SW+1)'(ctx_s5.hi_a);
		end
		r = (SW+1)'(ctx_s5.x) - b;
		v = b;
		if (ctx_s5.path == PATH_ZERO) begin
			if (ctx_s5.x < ctx_s5.lo) begin
				v = '0;
			end
		end else if (r < (SW+1)'(ctx_s5.lo)) begin
			v = (SW+1)'(ctx_s5.x) - (SW+1)'(ctx_s5.lo);
		end else if (r > hi) begin
			v = (SW+1)'(ctx_s5.x) - hi;
		end
		if (v < 0) begin
			res_c = '0;
		end else if (v[SW:VAL_W] != '0) begin
			res_c = VAL_SAT;
		end else begin
			res_c = v[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6 <= res_c;
		end
	end

	assign out_ch.valid = vld_q[LAT-1];
	assign out_ch.data = res_s6;

`ifndef SYNTHESIS
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("Stalled item changed.");
	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("Input refused with an empty output stage.");
	ap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctx_s5.path == PATH_ZERO && ctx_s5.x < ctx_s5.lo |=> res_s6 == '0)
		else $error("Purge below baseline.");
`endif
endmodule

// ----- bench/tb_streams.sv -----
`timescale 1ns / 1ps
// Payload layouts for the stream channels that the bench drives and samples.
// Depends on nothing; the bench instantiates cpac_stream_if from the design folder.
// This file only fixes the payload layouts the bench uses.
package tb_streams;
	localparam int unsigned FIELD_W = 52;
	localparam int unsigned QUERY_W = 4 * FIELD_W;
	typedef struct packed {
		logic [FIELD_W-1:0] disk_total;
		logic [FIELD_W-1:0] cache_usage;
		logic [FIELD_W-1:0] disk_used;
		logic [FIELD_W-1:0] recent_writes;
	} query_t;
endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for cache_purge_amount_calculator over cpac_stream_if channels.
// Random and directed queries under several watermark settings, checked against a
// purge amount predictor held in a scoreboard class. Also depends on cpac_pkg and tb_streams.
module tb_top;
	import cpac_pkg::*;
	import tb_streams::*;

	localparam logic [51:0] MASK = {52{1'b1}};
	localparam int FB = 32;
	localparam int WATCHDOG_LIMIT = 5000;

	class purge_scoreboard;
		bit [51:0] baseline, nominal, maximum, low_mark, high_mark;
		bit [51:0] purge_q[$];
		int errors;

		function void report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction

		function bit [63:0] share(longint num, longint den);
			bit [127:0] q;
			if (den <= 0 || num <= 0)
				return 0;
			q = ({64'd0, num} << FB) / {64'd0, den};
			if (q > {64'd0, {64{1'b1}}})
				return {64{1'b1}};
			return q[63:0];
		endfunction

		function longint scale_back(bit [63:0] f, longint m);
			bit [127:0] p;
			if (m <= 0)
				return 0;
			p = ({64'd0, f} * {64'd0, m}) >> FB;
			if (p > {76'd0, MASK})
				return longint'(MASK);
			return longint'(p[63:0]);
		endfunction

		function longint clamp(longint x, longint b, longint lo, longint hi);
			if (x - b < lo)
				return x - lo;
			if (x - b > hi)
				return x - hi;
			return b;
		endfunction

		function longint purge_amount(longint t, longint x, longint u, longint d);
			longint f0, f1, f2, w1, w2, b, top;
			bit [63:0] fu, fx;
			f0 = longint'(baseline);
			f1 = longint'(nominal);
			f2 = longint'(maximum);
			w1 = longint'(low_mark);
			w2 = longint'(high_mark);
			b = 0;
			if (x < f0)
				return 0;
			if (u >= w2) begin
				if (w2 == t) begin
					b = u - w1;
				end else begin
					fu = share(u - w2, t - w2);
					fx = share(x - f0, f1 - f0);
					if (fx > fu) begin
						b = scale_back(fx - fu, f1 - f0) + d;
						return clamp(x, b, f0, f1);
					end
					return clamp(x, b, f0, f2);
				end
			end
			if (u > w1 && x > f1) begin
				fu = share(u - w1, w2 - w1);
				fx = share(x - f1, f2 - f1);
				if (fx > fu)
					b = scale_back(fx - fu, f2 - f1) + d;
				return clamp(x, b, f0, f2);
			end
			if (x > f2) begin
				top = f2 - d;
				if (top < f0)
					top = f0;
				return clamp(x, b, f0, top);
			end
			return b;
		endfunction

		function void note_query(query_t q);
			longint r;
			r = purge_amount(longint'(q.disk_total), longint'(q.cache_usage),
				longint'(q.disk_used), longint'(q.recent_writes));
			if (r < 0)
				r = 0;
			if (r > longint'(MASK))
				r = longint'(MASK);
			purge_q = {purge_q, r[51:0]};
		endfunction

		function void check_purge(bit [51:0] got);
			bit [51:0] want;
			if (purge_q.size() == 0) begin
				report($sformatf("unexpected purge_bytes %0d", got));
				return;
			end
			want = purge_q[0];
			purge_q.delete(0);
			if (got !== want)
				report($sformatf("purge_bytes %0d, expected %0d", got, want));
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [63:0] pwdata, prdata;

	cpac_stream_if #(.W(QUERY_W)) in_ch ();
	cpac_stream_if #(.W(FIELD_W)) out_ch ();

	cache_purge_amount_calculator uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	purge_scoreboard sb = new();
	int send_idle_pct, recv_stall_pct, hold_cycles, quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_query(query_t'(in_ch.data));
			if (out_ch.valid && out_ch.ready)
				sb.check_purge(out_ch.data);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input bit [51:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {12'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			REG_BASELINE: sb.baseline = value;
			REG_NOMINAL: sb.nominal = value;
			REG_MAXIMUM: sb.maximum = value;
			REG_LOW_MARK: sb.low_mark = value;
			REG_HIGH_MARK: sb.high_mark = value;
			default: ;
		endcase
	endtask

	task automatic set_marks(input bit [51:0] f0, f1, f2, w1, w2);
		write_reg(REG_BASELINE, f0);
		write_reg(REG_NOMINAL, f1);
		write_reg(REG_MAXIMUM, f2);
		write_reg(REG_LOW_MARK, w1);
		write_reg(REG_HIGH_MARK, w2);
	endtask

	task automatic drain();
		while (sb.purge_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic send_query(input query_t q);
		bit taken;
		in_ch.valid <= 1'b1;
		in_ch.data <= q;
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	function automatic bit [51:0] near(bit [51:0] base);
		case ($urandom_range(7))
			0: return base;
			1: return base + 52'($urandom_range(1000));
			2: return base - 52'($urandom_range(1000));
			3: return 52'({$urandom, $urandom} & MASK);
			4: return 52'($urandom_range(3));
			5: return MASK - 52'($urandom_range(3));
			default: return 52'(base + (({$urandom, $urandom} & MASK)
				>> $urandom_range(51, 20)));
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		bit [51:0] marks[5];
		marks = '{sb.baseline, sb.nominal, sb.maximum, sb.low_mark, sb.high_mark};
		q.disk_total = ($urandom_range(5) == 0) ? sb.high_mark : near(marks[4]);
		q.cache_usage = near(marks[$urandom_range(2)]);
		q.disk_used = near(marks[$urandom_range(4, 3)]);
		q.recent_writes = ($urandom_range(1) != 0) ? 52'($urandom_range(100000))
			: near(marks[$urandom_range(4)]);
		return q;
	endfunction

	function automatic bit [51:0] rnd(int shift);
		return 52'(({$urandom, $urandom} & MASK) >> shift);
	endfunction

	initial begin
		bit [51:0] a, b, c, e;
		int items;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		@(posedge arst_n);
		@(posedge clk);

		send_query('{52'd0, 52'd0, 52'd0, 52'd0});
		send_query('{MASK, MASK, MASK, MASK});
		in_ch.valid <= 1'b0;
		drain();
		set_marks(52'd1000, 52'd5000, 52'd8000, 52'd60000, 52'd90000);
		send_query('{52'd100000, 52'd999, 52'd95000, 52'd10});
		send_query('{52'd100000, 52'd7000, 52'd95000, 52'd10});
		send_query('{52'd100000, 52'd4000, 52'd99000, 52'd0});
		send_query('{52'd100000, 52'd7500, 52'd70000, 52'd200});
		send_query('{52'd100000, 52'd7500, 52'd89000, 52'd0});
		send_query('{52'd100000, 52'd9000, 52'd30000, 52'd500});
		send_query('{52'd100000, 52'd9000, 52'd30000, 52'd50000});
		send_query('{52'd90000, 52'd7000, 52'd95000, 52'd0});
		send_query('{52'd90000, 52'd2000, 52'd90000, 52'd3});
		send_query('{52'd90000, MASK, MASK, MASK});
		send_query('{MASK, 52'd6000, MASK, 52'd0});
		send_query('{52'd0, 52'd6000, 52'd95000, 52'd0});
		in_ch.valid <= 1'b0;
		drain();
		set_marks(MASK, MASK, MASK, MASK, MASK);
		send_query('{MASK, MASK, MASK, MASK});
		send_query('{MASK, MASK, MASK, 52'd0});
		send_query('{52'd0, MASK, MASK, 52'd0});
		in_ch.valid <= 1'b0;
		drain();
		set_marks(52'd0, 52'd0, 52'd0, 52'd0, 52'd0);
		send_query('{52'd5, MASK, 52'd3, 52'd1});
		send_query('{MASK, 52'd1, MASK, MASK});
		in_ch.valid <= 1'b0;

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			case (ph)
				0: begin
					a = rnd(12); b = a + rnd(14); c = b + rnd(14);
					e = rnd(8);
					set_marks(a, b, c, e, e + rnd(10));
				end
				1: set_marks(52'd0, 52'd0, 52'd0, 52'd0, 52'd0);
				2: set_marks(MASK, MASK, MASK, MASK, MASK);
				3: set_marks(rnd(0), rnd(0), rnd(0), rnd(0), rnd(0));
				4: begin
					a = rnd(36); b = a + rnd(36); c = b + rnd(36);
					e = rnd(34);
					set_marks(a, b, c, e, e + rnd(34));
				end
				5: set_marks(52'd0, MASK >> 1, MASK, MASK >> 2, MASK - 52'd7);
				6: begin
					a = rnd(20); b = a + rnd(20);
					set_marks(a, b, b + 52'd1, rnd(4), rnd(2));
				end
				default: begin
					a = rnd(6); b = a + rnd(6);
					set_marks(a, b, b + rnd(8), rnd(2), rnd(1));
				end
			endcase
			if (ph == 2)
				hold_cycles = 400;
			items = 200;
			for (int i = 0; i < items; i++) begin
				if (ph == 5 && i == items / 2) begin
					in_ch.valid <= 1'b0;
					while (sb.purge_q.size() != 0)
						@(posedge clk);
				end
				send_query(random_query());
			end
			in_ch.valid <= 1'b0;
		end
		drain();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
